// ===== sv/dda_pkg.sv =====
// Shared constants, command type and back-end state type for the DDA line rasterizer.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps

package dda_pkg;

  // Coordinate and fixed-point geometry
  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_W     = FRAC_BITS + 2;
  localparam int QUOT_W     = FRAC_BITS + 1;
  localparam int REM_W      = COORD_BITS + 1;
  localparam int DIV_ITERS  = QUOT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

  // Command queue geometry
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input item kinds
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // Classified command passed from the front end to the back end
  typedef struct packed {
    logic                  is_start;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic                  neg_x;
    logic                  neg_y;
    logic [COORD_BITS-1:0] steps;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic {
    BK_RUN,
    BK_DIV
  } back_state_t;

endpackage

// ===== sv/dda_front.sv =====
// Front end: accepts input transfers, computes deltas and step count, queues commands.
// Depends on dda_pkg.
`timescale 1ns / 1ps

module dda_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [dda_pkg::COORD_BITS-1:0] x_start,
  input  logic [dda_pkg::COORD_BITS-1:0] y_start,
  input  logic [dda_pkg::COORD_BITS-1:0] x_end,
  input  logic [dda_pkg::COORD_BITS-1:0] y_end,
  output logic                          head_valid,
  output dda_pkg::cmd_t                 head,
  input  logic                          pop
);
  import dda_pkg::*;

  cmd_t              entry [QDEPTH];
  cmd_t              cmd_in;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              do_pop;

  // Classify: signs, magnitudes and major-axis length
  always_comb begin
    cmd_in.is_start = (kind == KIND_START);
    cmd_in.x_start  = x_start;
    cmd_in.y_start  = y_start;
    cmd_in.neg_x    = x_end < x_start;
    cmd_in.neg_y    = y_end < y_start;
    cmd_in.mag_x    = cmd_in.neg_x ? (x_start - x_end) : (x_end - x_start);
    cmd_in.mag_y    = cmd_in.neg_y ? (y_start - y_end) : (y_end - y_start);
    cmd_in.steps    = (cmd_in.mag_x > cmd_in.mag_y) ? cmd_in.mag_x : cmd_in.mag_y;
  end

  assign in_ready   = (count != QCNT_W'(QDEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = entry[rd_ptr];

  // Store classified commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/dda_div.sv =====
// Bit-serial restoring divider: both axis increments, (mag << FRAC_BITS) / steps.
// Depends on dda_pkg. One quotient bit per axis each cycle.
`timescale 1ns / 1ps

module dda_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dda_pkg::COORD_BITS-1:0] divisor,
  input  logic [dda_pkg::COORD_BITS-1:0] mag_x,
  input  logic [dda_pkg::COORD_BITS-1:0] mag_y,
  output logic                           done,
  output logic [dda_pkg::QUOT_W-1:0]     quot_x,
  output logic [dda_pkg::QUOT_W-1:0]     quot_y
);
  import dda_pkg::*;

  logic [COORD_BITS-1:0] dvs;
  logic [REM_W-1:0]      rem_x;
  logic [REM_W-1:0]      rem_y;
  logic [REM_W:0]        diff_x;
  logic [REM_W:0]        diff_y;
  logic [REM_W-1:0]      rem_x_next;
  logic [REM_W-1:0]      rem_y_next;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  busy;

  // Trial subtract; the dividend starts at most equal to the divisor
  always_comb begin
    diff_x     = {1'b0, rem_x} - {2'b00, dvs};
    diff_y     = {1'b0, rem_y} - {2'b00, dvs};
    rem_x_next = diff_x[REM_W] ? rem_x : diff_x[REM_W-1:0];
    rem_y_next = diff_y[REM_W] ? rem_y : diff_y[REM_W-1:0];
  end

  // Datapath: partial remainders and quotients
  always_ff @(posedge clk) begin
    if (start) begin
      dvs    <= divisor;
      rem_x  <= {1'b0, mag_x};
      rem_y  <= {1'b0, mag_y};
      quot_x <= '0;
      quot_y <= '0;
    end else if (busy) begin
      rem_x  <= {rem_x_next[REM_W-2:0], 1'b0};
      rem_y  <= {rem_y_next[REM_W-2:0], 1'b0};
      quot_x <= {quot_x[QUOT_W-2:0], ~diff_x[REM_W]};
      quot_y <= {quot_y[QUOT_W-2:0], ~diff_y[REM_W]};
    end
  end

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_ITERS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/dda_back.sv =====
// Back end: pops commands, runs the increment division on starts, steps and emits pixels.
// Depends on dda_pkg and dda_div.
`timescale 1ns / 1ps

module dda_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  dda_pkg::cmd_t                  head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dda_pkg::COORD_BITS-1:0] pixel_x,
  output logic [dda_pkg::COORD_BITS-1:0] pixel_y,
  output logic                           last
);
  import dda_pkg::*;

  back_state_t           state;
  back_state_t           state_next;
  logic                  div_start;
  logic                  div_done;
  logic [QUOT_W-1:0]     quot_x;
  logic [QUOT_W-1:0]     quot_y;
  logic                  emit;
  logic                  load_start;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;
  logic [STEP_W-1:0]     step_x;
  logic [STEP_W-1:0]     step_y;
  logic [COORD_BITS-1:0] remaining;
  logic [COORD_BITS-1:0] pend_steps;
  logic                  pend_neg_x;
  logic                  pend_neg_y;
  logic [POS_W-1:0]      round_x;
  logic [POS_W-1:0]      round_y;
  logic [STEP_W-1:0]     mag_step_x;
  logic [STEP_W-1:0]     mag_step_y;

  localparam logic [POS_W-1:0] HALF_LSB = POS_W'(1) << (FRAC_BITS - 1);

  dda_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (head.steps),
    .mag_x   (head.mag_x),
    .mag_y   (head.mag_y),
    .done    (div_done),
    .quot_x  (quot_x),
    .quot_y  (quot_y)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_RUN: begin
        if (head_valid && head.is_start && (head.steps != '0)) begin
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  // Sequencer outputs: pop, divider kick, pixel emit
  always_comb begin
    pop        = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    load_start = 1'b0;
    unique case (state)
      BK_RUN: begin
        if (head_valid) begin
          if (head.is_start) begin
            pop        = 1'b1;
            load_start = 1'b1;
            div_start  = (head.steps != '0);
          end else if (remaining == '0) begin
            pop = 1'b1;
          end else if (!out_valid || out_ready) begin
            pop  = 1'b1;
            emit = 1'b1;
          end
        end
      end
      BK_DIV: begin
        pop = 1'b0;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Round half up to the pixel grid
  always_comb begin
    round_x    = pos_x + HALF_LSB;
    round_y    = pos_y + HALF_LSB;
    mag_step_x = {1'b0, quot_x};
    mag_step_y = {1'b0, quot_y};
  end

  // Line state: position, increments, pixels left
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= '0;
      pos_y     <= '0;
      step_x    <= '0;
      step_y    <= '0;
      remaining <= '0;
    end else if (load_start) begin
      pos_x     <= {1'b0, head.x_start, {FRAC_BITS{1'b0}}};
      pos_y     <= {1'b0, head.y_start, {FRAC_BITS{1'b0}}};
      step_x    <= '0;
      step_y    <= '0;
      remaining <= '0;
    end else if (div_done) begin
      step_x    <= pend_neg_x ? (~mag_step_x + 1'b1) : mag_step_x;
      step_y    <= pend_neg_y ? (~mag_step_y + 1'b1) : mag_step_y;
      remaining <= pend_steps;
    end else if (emit) begin
      pos_x     <= pos_x + {{(POS_W-STEP_W){step_x[STEP_W-1]}}, step_x};
      pos_y     <= pos_y + {{(POS_W-STEP_W){step_y[STEP_W-1]}}, step_y};
      remaining <= remaining - 1'b1;
    end
  end

  // Hold start parameters while the division runs
  always_ff @(posedge clk) begin
    if (load_start) begin
      pend_steps <= head.steps;
      pend_neg_x <= head.neg_x;
      pend_neg_y <= head.neg_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x <= round_x[FRAC_BITS +: COORD_BITS];
      pixel_y <= round_y[FRAC_BITS +: COORD_BITS];
      last    <= (remaining == COORD_BITS'(1));
    end
  end

endmodule

// ===== sv/dda_line_rasterizer.sv =====
// DDA line rasterizer top level. A pixel is computed when its advance transfer is at the head
// of the two-entry command queue and is presented from the output register; advances sustain
// one per cycle while the output is not stalled. A nonzero-length start holds the back end in
// BK_DIV for the serial divider (one quotient bit per cycle); zero-length starts and idle advances do not.
// Synchronous active-high reset empties the queue and leaves the rasterizer idle.
// Depends on dda_pkg, dda_front, dda_back (which holds dda_div).
`timescale 1ns / 1ps

module dda_line_rasterizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [dda_pkg::COORD_BITS-1:0] x_start,
  input  logic [dda_pkg::COORD_BITS-1:0] y_start,
  input  logic [dda_pkg::COORD_BITS-1:0] x_end,
  input  logic [dda_pkg::COORD_BITS-1:0] y_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dda_pkg::COORD_BITS-1:0] pixel_x,
  output logic [dda_pkg::COORD_BITS-1:0] pixel_y,
  output logic                           last
);
  import dda_pkg::*;

  logic head_valid;
  cmd_t head;
  logic pop;

  dda_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  dda_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last       (last)
  );

endmodule

// ===== tb/tb_dda_line_rasterizer.sv =====
// Self-checking testbench for dda_line_rasterizer: directed and random line starts and advances.
// A scoreboard class predicts each pixel. Depends on dda_pkg and the dda_line_rasterizer RTL.
`timescale 1ns / 1ps

module tb_dda_line_rasterizer;
  import dda_pkg::*;

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int ITEM_TARGET = 450;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int LOG_CAP     = 50;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } pixel_t;

  typedef enum int {RX_OPEN, RX_SPARSE, RX_CADENCE, RX_COIN} rx_mode_t;

  // Line tracker: mirrors the DDA position, increments and pixel count
  class pixel_scoreboard;
    logic [POS_W-1:0]         cur_x, cur_y;
    logic signed [STEP_W-1:0] inc_x, inc_y;
    logic [REM_W-1:0]         pixels_left;
    pixel_t                   pixel_q[$];
    int                       errors;
    int                       starts;
    int                       advances;
    int                       checked;

    function new();
      cur_x = '0;
      cur_y = '0;
      inc_x = '0;
      inc_y = '0;
      pixels_left = '0;
      errors = 0;
      starts = 0;
      advances = 0;
      checked = 0;
    endfunction

    function logic signed [STEP_W-1:0] axis_increment(int delta, int steps);
      longint mag;
      longint quot;
      mag = (delta < 0) ? -delta : delta;
      quot = (mag << FRAC_BITS) / steps;
      return (delta < 0) ? -STEP_W'(quot) : STEP_W'(quot);
    endfunction

    function logic [COORD_BITS-1:0] round_coord(logic [POS_W-1:0] pos);
      logic [POS_W-1:0] biased;
      biased = pos + (POS_W'(1) << (FRAC_BITS - 1));
      return biased[FRAC_BITS +: COORD_BITS];
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    // Update the line state for one input transfer and queue its pixel, if any
    function void note_transfer(logic k, logic [COORD_BITS-1:0] xs, logic [COORD_BITS-1:0] ys,
                                logic [COORD_BITS-1:0] xe, logic [COORD_BITS-1:0] ye);
      int     dx, dy, adx, ady, steps;
      pixel_t pix;
      if (k == KIND_START) begin
        starts++;
        dx = int'(xe) - int'(xs);
        dy = int'(ye) - int'(ys);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        steps = (adx > ady) ? adx : ady;
        cur_x = POS_W'(xs) << FRAC_BITS;
        cur_y = POS_W'(ys) << FRAC_BITS;
        if (steps == 0) begin
          inc_x = '0;
          inc_y = '0;
          pixels_left = '0;
        end else begin
          inc_x = axis_increment(dx, steps);
          inc_y = axis_increment(dy, steps);
          pixels_left = REM_W'(steps);
        end
      end else begin
        advances++;
        if (pixels_left != 0) begin
          pix.x = round_coord(cur_x);
          pix.y = round_coord(cur_y);
          pix.last = (pixels_left == 1);
          pixel_q.push_back(pix);
          cur_x = cur_x + {{(POS_W - STEP_W){inc_x[STEP_W-1]}}, inc_x};
          cur_y = cur_y + {{(POS_W - STEP_W){inc_y[STEP_W-1]}}, inc_y};
          pixels_left = pixels_left - 1'b1;
        end
      end
    endfunction

    task report(string msg);
      // keep the log readable when many mismatches pile up
      if (errors < LOG_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one output transfer with the oldest predicted pixel
    task check_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py, logic lst);
      pixel_t exp_pix;
      if (pixel_q.size() == 0) begin
        report($sformatf("unexpected pixel (%0d,%0d) last=%0b", px, py, lst));
      end else begin
        exp_pix = pixel_q.pop_front();
        checked++;
        if (px !== exp_pix.x)
          report($sformatf("pixel_x got %0d expected %0d", px, exp_pix.x));
        if (py !== exp_pix.y)
          report($sformatf("pixel_y got %0d expected %0d", py, exp_pix.y));
        if (lst !== exp_pix.last)
          report($sformatf("last got %0b expected %0b at (%0d,%0d)", lst, exp_pix.last,
                           exp_pix.x, exp_pix.y));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  kind = KIND_START;
  logic [COORD_BITS-1:0] x_start = '0;
  logic [COORD_BITS-1:0] y_start = '0;
  logic [COORD_BITS-1:0] x_end = '0;
  logic [COORD_BITS-1:0] y_end = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last;

  pixel_scoreboard sb = new();
  int              items_sent = 0;
  int              burst_left = 0;
  int              holds_requested = 0;
  int              quiet_cycles = 0;

  dda_line_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last      (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_pixel(pixel_x, pixel_y, last);
  end

  // Abort when no transfer happens on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: switch between stall patterns, serve long hold-off requests
  initial begin
    rx_mode_t mode;
    int       phase_left;
    int       hold_left;
    int       holds_served;
    int       tick;
    mode = RX_OPEN;
    phase_left = 0;
    hold_left = 0;
    holds_served = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          phase_left = $urandom_range(20, 80);
        end
        phase_left--;
        tick++;
        case (mode)
          RX_OPEN:    out_ready <= 1'b1;
          RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
          RX_CADENCE: out_ready <= (tick % 5 != 0);
          default:    out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] any_coord();
    return COORD_BITS'($urandom_range(0, COORD_MAX));
  endfunction

  function automatic logic [COORD_BITS-1:0] near_coord(int c, int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_BITS'(v);
  endfunction

  // Offer one item in bursts with random gaps, hold until transferred
  task automatic send_item(logic k, logic [COORD_BITS-1:0] xs, logic [COORD_BITS-1:0] ys,
                           logic [COORD_BITS-1:0] xe, logic [COORD_BITS-1:0] ye);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    kind     <= k;
    x_start  <= xs;
    y_start  <= ys;
    x_end    <= xe;
    y_end    <= ye;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_transfer(k, xs, ys, xe, ye);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_advance();
    send_item(KIND_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord());
  endtask

  task automatic line_run(logic [COORD_BITS-1:0] xs, logic [COORD_BITS-1:0] ys,
                          logic [COORD_BITS-1:0] xe, logic [COORD_BITS-1:0] ye, int adv);
    send_item(KIND_START, xs, ys, xe, ye);
    repeat (adv) send_advance();
  endtask

  // Start a line and advance it fully, partly (abandon) or past its end
  task automatic random_line(logic [COORD_BITS-1:0] xs, logic [COORD_BITS-1:0] ys,
                             logic [COORD_BITS-1:0] xe, logic [COORD_BITS-1:0] ye);
    int adx, ady, steps, adv;
    adx = (xe > xs) ? int'(xe - xs) : int'(xs - xe);
    ady = (ye > ys) ? int'(ye - ys) : int'(ys - ye);
    steps = (adx > ady) ? adx : ady;
    case ($urandom_range(0, 9))
      0:       adv = $urandom_range(0, steps);
      1:       adv = steps + $urandom_range(1, 3);
      default: adv = steps;
    endcase
    line_run(xs, ys, xe, ye, adv);
  endtask

  // Stop offering until every predicted pixel has come out
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [COORD_BITS-1:0] bx, by;
    int                    span;
    bit                    drained;
    drained = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle advance, zero-length line, half-step rounding, corners, abandon, steep
    send_item(KIND_ADVANCE, '1, '1, '1, '1);
    send_item(KIND_START, 10'd7, 10'd7, 10'd7, 10'd7);
    send_item(KIND_ADVANCE, '0, '0, '0, '0);
    line_run(10'd0, 10'd0, 10'd4, 10'd2, 5);
    line_run(10'd1023, 10'd1023, 10'd0, 10'd0, 2);
    line_run(10'd0, 10'd1023, 10'd1023, 10'd0, 2);
    line_run(10'd10, 10'd20, 10'd7, 10'd27, 7);

    // Random: mostly short lines, some long abandoned ones, some noise
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 150 && holds_requested == 0) begin
        // receiver goes quiet while a long line keeps the input busy
        holds_requested++;
        bx = near_coord(500, 400);
        by = near_coord(500, 400);
        line_run(bx, by, bx + 10'd40, by + 10'd17, 40);
      end else if (items_sent >= 300 && !drained) begin
        drain();
        drained = 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0, 1: send_item(1'($urandom_range(0, 1)), any_coord(), any_coord(), any_coord(),
                          any_coord());
          2:    line_run(any_coord(), any_coord(), any_coord(), any_coord(),
                         $urandom_range(3, 25));
          default: begin
            span = ($urandom_range(0, 3) == 0) ? 64 : 12;
            bx = any_coord();
            by = any_coord();
            random_line(bx, by, near_coord(int'(bx), span), near_coord(int'(by), span));
          end
        endcase
      end
    end

    // Let the block finish, then allow for a trailing line start
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (FRAC_BITS + 8) @(posedge clk);

    $display("Summary: %0d items, %0d line starts, %0d advances, %0d pixels checked",
             items_sent, sb.starts, sb.advances, sb.checked);
    $display("Summary: %0d long receiver hold-off(s), one full drain pause", holds_requested);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
